### hdl/rctd_pkg.sv
// ----------------------------------------------------------------------------
// rctd_pkg: shared types and constants of the radio clock time code decoder
// timer width, frame layout, status and register codes, interface structs
// ----------------------------------------------------------------------------
package rctd_pkg;

	localparam int TIME_W       = 16;
	localparam int FRAME_W      = 64;
	localparam int POS_W        = $clog2(FRAME_W);
	localparam int COUNT_W      = 7;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [COUNT_W-1:0] FRAME_MIN_BITS = 7'd59;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;

	localparam logic [CFG_DATA_W-1:0] GAP_RST      = 16'd52428;
	localparam logic [CFG_DATA_W-1:0] ZERO_MIN_RST = 16'd2458;
	localparam logic [CFG_DATA_W-1:0] ZERO_MAX_RST = 16'd4096;
	localparam logic [CFG_DATA_W-1:0] ONE_MIN_RST  = 16'd5734;
	localparam logic [CFG_DATA_W-1:0] ONE_MAX_RST  = 16'd7373;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_SHORT  = 2'd1,
		STATUS_PARITY = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MINUTE_GAP_MIN = 3'd0,
		REG_ZERO_WIDTH_MIN = 3'd1,
		REG_ZERO_WIDTH_MAX = 3'd2,
		REG_ONE_WIDTH_MIN  = 3'd3,
		REG_ONE_WIDTH_MAX  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [TIME_W-1:0] minute_gap_min;
		logic [TIME_W-1:0] zero_width_min;
		logic [TIME_W-1:0] zero_width_max;
		logic [TIME_W-1:0] one_width_min;
		logic [TIME_W-1:0] one_width_max;
	} cfg_regs_t;

	// what the edge stage tells the rest about the event under way
	typedef struct packed {
		logic                marker;
		logic [FRAME_W-1:0]  frame;
		logic [COUNT_W-1:0]  count;
	} edge_info_t;

	typedef struct packed {
		status_t     status;
		logic [6:0]  minute;
		logic [5:0]  hour;
		logic [5:0]  day;
		logic [4:0]  month;
		logic [7:0]  year;
	} decode_t;

endpackage

### hdl/rctd_edge.sv
// ----------------------------------------------------------------------------
// rctd_edge: edge tracking, pulse classification and frame store
// keeps the last level and edge time, appends classified bits, spots markers
// ----------------------------------------------------------------------------
module rctd_edge
	import rctd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_regs_t         cfg,
	input  logic              fire,
	input  logic [TIME_W-1:0] capture_time,
	input  logic              signal_level,
	output edge_info_t        info
);

	logic                level_q;
	logic [TIME_W-1:0]   edge_time_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [COUNT_W-1:0]  count_q;

	logic              changed;
	logic [TIME_W-1:0] diff;
	logic              is_zero;
	logic              is_one;
	logic              append;
	logic              marker;

	always_comb begin
		changed = signal_level != level_q;
		diff    = capture_time - edge_time_q;
		is_zero = (diff > cfg.zero_width_min) && (diff < cfg.zero_width_max);
		is_one  = (diff > cfg.one_width_min) && (diff < cfg.one_width_max);
		append  = changed && !signal_level && (is_zero || is_one);
		marker  = changed && signal_level && (diff > cfg.minute_gap_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 1'b0;
			edge_time_q <= '0;
			frame_q     <= '0;
			count_q     <= '0;
		end else if (fire && changed) begin
			level_q     <= signal_level;
			edge_time_q <= capture_time;
			if (marker) begin
				frame_q <= '0;
				count_q <= '0;
			end else if (append) begin
				// zero window wins when both match
				frame_q[count_q[POS_W-1:0]] <= !is_zero;
				if (count_q != COUNT_MAX)
					count_q <= count_q + 7'd1;
			end
		end
	end

	assign info.marker = marker;
	assign info.frame  = frame_q;
	assign info.count  = count_q;

endmodule

### hdl/rctd_decode.sv
// ----------------------------------------------------------------------------
// rctd_decode: frame check and time field conversion
// length and even parity checks, bcd digits to binary
// ----------------------------------------------------------------------------
module rctd_decode
	import rctd_pkg::*;
(
	input  logic [FRAME_W-1:0] frame,
	input  logic [COUNT_W-1:0] count,
	output decode_t            dec
);

	logic parity_ok;

	// tens * 10 as two shifts
	function automatic logic [7:0] bcd2bin(input logic [3:0] tens, input logic [3:0] units);
		logic [7:0] t8;
		t8 = {4'd0, tens};
		return (t8 << 3) + (t8 << 1) + {4'd0, units};
	endfunction

	always_comb begin
		parity_ok = !(^frame[28:21]) && !(^frame[35:29]) && !(^frame[58:36]);
		if (count < FRAME_MIN_BITS)
			dec.status = STATUS_SHORT;
		else if (parity_ok)
			dec.status = STATUS_OK;
		else
			dec.status = STATUS_PARITY;
		dec.minute = 7'(bcd2bin({1'b0, frame[27:25]}, frame[24:21]));
		dec.hour   = 6'(bcd2bin({2'b0, frame[34:33]}, frame[32:29]));
		dec.day    = 6'(bcd2bin({2'b0, frame[41:40]}, frame[39:36]));
		dec.month  = 5'(bcd2bin({3'b0, frame[49]}, frame[48:45]));
		dec.year   = bcd2bin(frame[57:54], frame[53:50]);
	end

endmodule

### hdl/radio_clock_time_code_decoder.sv
// ----------------------------------------------------------------------------
// radio_clock_time_code_decoder: minute frame decoder for a long-wave time code
// takes edge events, gathers pulse-width bits, decodes at the minute marker
// ----------------------------------------------------------------------------
// an accepted event beat passes the input register, then the result register, to its result beat
// throughput: one event per cycle; the input register feeds the edge stage and
//   the decode logic in one pass, the result register parts the output side
// an event is held back only while a marker result meets a full, stalled output
// reset: asynchronous, active low; clears frame, held time, ready flag, valids
//   and loads the threshold registers with their default values
module radio_clock_time_code_decoder
	import rctd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// event channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_W-1:0]     capture_time,
	input  logic                  signal_level,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            decode_status,
	output logic [COUNT_W-1:0]    bits_received,
	output logic [6:0]            held_minute,
	output logic [5:0]            held_hour,
	output logic [5:0]            held_day,
	output logic [4:0]            held_month,
	output logic [7:0]            held_year,
	output logic                  time_ready,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_regs_t cfg_q;

	// input register
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic              level_s1;

	// held time of the last good frame
	logic [6:0] minute_q;
	logic [5:0] hour_q;
	logic [4:0] month_q;
	logic [5:0] day_q;
	logic [7:0] year_q;
	logic       ready_q;

	// result register
	logic    res_valid_q;
	decode_t res_q;
	logic [COUNT_W-1:0] res_count_q;
	logic    res_ready_q;

	edge_info_t info;
	decode_t    dec;
	logic       in_beat;
	logic       out_beat;
	logic       block;
	logic       fire;
	logic       emit;
	logic       good;

	// ------------------------------------------------------------------
	// configuration registers, always ready
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.minute_gap_min <= GAP_RST;
			cfg_q.zero_width_min <= ZERO_MIN_RST;
			cfg_q.zero_width_max <= ZERO_MAX_RST;
			cfg_q.one_width_min  <= ONE_MIN_RST;
			cfg_q.one_width_max  <= ONE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MINUTE_GAP_MIN: cfg_q.minute_gap_min <= cfg_data;
				REG_ZERO_WIDTH_MIN: cfg_q.zero_width_min <= cfg_data;
				REG_ZERO_WIDTH_MAX: cfg_q.zero_width_max <= cfg_data;
				REG_ONE_WIDTH_MIN:  cfg_q.one_width_min  <= cfg_data;
				REG_ONE_WIDTH_MAX:  cfg_q.one_width_max  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake: the event in the input register moves on unless it is a
	// marker and the result register is full and stalled
	// ------------------------------------------------------------------
	assign out_beat = res_valid_q && !out_stall;
	assign block    = info.marker && res_valid_q && out_stall;
	assign fire     = valid_s1 && !block;
	assign emit     = fire && info.marker;
	assign in_stall = valid_s1 && block;
	assign in_beat  = in_valid && !in_stall;
	assign good     = dec.status == STATUS_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			time_s1  <= capture_time;
			level_s1 <= signal_level;
		end
	end

	rctd_edge u_edge (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.fire         (fire),
		.capture_time (time_s1),
		.signal_level (level_s1),
		.info         (info)
	);

	rctd_decode u_decode (
		.frame (info.frame),
		.count (info.count),
		.dec   (dec)
	);

	// held time, replaced only by a frame that passes every check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			minute_q <= '0;
			hour_q   <= '0;
			day_q    <= '0;
			month_q  <= '0;
			year_q   <= '0;
			ready_q  <= 1'b0;
		end else if (emit && good) begin
			minute_q <= dec.minute;
			hour_q   <= dec.hour;
			day_q    <= dec.day;
			month_q  <= dec.month;
			year_q   <= dec.year;
			ready_q  <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// result register: carries the held time as it stands after this decode
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit)
			res_valid_q <= 1'b1;
		else if (out_beat)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.status <= dec.status;
			res_count_q  <= info.count;
			if (good) begin
				res_q.minute <= dec.minute;
				res_q.hour   <= dec.hour;
				res_q.day    <= dec.day;
				res_q.month  <= dec.month;
				res_q.year   <= dec.year;
				res_ready_q  <= 1'b1;
			end else begin
				res_q.minute <= minute_q;
				res_q.hour   <= hour_q;
				res_q.day    <= day_q;
				res_q.month  <= month_q;
				res_q.year   <= year_q;
				res_ready_q  <= ready_q;
			end
		end
	end

	assign out_valid     = res_valid_q;
	assign decode_status = res_q.status;
	assign bits_received = res_count_q;
	assign held_minute   = res_q.minute;
	assign held_hour     = res_q.hour;
	assign held_day      = res_q.day;
	assign held_month    = res_q.month;
	assign held_year     = res_q.year;
	assign time_ready    = res_ready_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	// once a good frame is seen the time stays valid
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ready_q))
		else $error("ready flag dropped");

	// a good decode always reports a valid time
	a_ok_has_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decode_status == STATUS_OK |-> time_ready)
		else $error("good status without ready flag");

	// a short frame really had too few bits
	a_short_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decode_status == STATUS_SHORT |-> bits_received < FRAME_MIN_BITS)
		else $error("short status with full frame");

	// the marker empties the frame store
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> info.count == '0)
		else $error("frame not cleared after marker");

endmodule
